// ===== design/vgrt_pkg.sv =====
// Shared widths, coefficients, register indexes and codes for the restart trigger.
package vgrt_pkg;

    localparam int GLUE_W     = 32;
    localparam int RST_W      = 32;
    localparam int LEVEL_W    = 24;
    localparam int WIN_W      = 16;
    localparam int VAR_W      = 48;
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 3 * MUL_W;
    localparam int MAG_W      = WIN_W + GLUE_W;
    localparam int SQ_W       = PROD_W;
    localparam int FS_W       = GLUE_W + 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = WIN_W;
    localparam int COEF_SHIFT = 16;
    localparam int MIN_SINCE  = 50;

    localparam logic [VAR_W-1:0] VAR_MAX           = '1;
    localparam logic [MUL_W-1:0] KEEP_COEF         = 32'd62259;
    localparam logic [MUL_W-1:0] NEW_COEF          = 32'd3277;
    localparam logic [WIN_W-1:0] FAST_WINDOW_RESET = 16'd33;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESTART_ENABLE = 1'b0,
        REG_FAST_WINDOW    = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SCALE_ONE,
        SCALE_UP,
        SCALE_DOWN
    } scale_t;

endpackage

// ===== design/variance_gated_restart_trigger.sv =====
// Top level of the variance gated restart trigger with its multiply sequencer.
// Each item yields one do_restart answer. When restarts are disabled, the decision
// level is zero or stable mode is set, an item goes from ST_IDLE straight to ST_DONE,
// which registers its answer. In focused mode it passes ST_UPD, then ST_MAG to ST_VUPD
// when a new conflict updates the glue variance, then ST_SQ, ST_CMP, ST_DEC and ST_DONE;
// the single 32 by 32 bit multiplier is used once per cycle for the variance partial
// products and the slow glue square. A finished answer waits in the output register while
// the next item is taken; an item only holds back when that register is still full at its end.
module variance_gated_restart_trigger #(
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 48
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [COUNT_BITS-1:0]           conflict_count,
    input  logic [vgrt_pkg::RST_W-1:0]      restart_count,
    input  logic [vgrt_pkg::GLUE_W-1:0]     fast_avg,
    input  logic [vgrt_pkg::GLUE_W-1:0]     slow_avg,
    input  logic [vgrt_pkg::LEVEL_W-1:0]    decision_level,
    input  logic                            stable_mode,
    input  logic                            reluctant_fired,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            do_restart,
    input  logic                            cfg_write,
    input  logic [vgrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vgrt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import vgrt_pkg::*;

    localparam int CMP_W = 70 + FRAC_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD,
        ST_MAG,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_K0,
        ST_K1,
        ST_N0,
        ST_N1,
        ST_VUPD,
        ST_SQ,
        ST_CMP,
        ST_DEC,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  do_restart_reg, do_restart_next;
    logic                  enable_reg, enable_next;
    logic [WIN_W-1:0]      window_reg, window_next;
    logic [VAR_W-1:0]      var_reg, var_next;
    logic [GLUE_W-1:0]     prev_fast_reg, prev_fast_next;
    logic [COUNT_BITS-1:0] seen_conf_reg, seen_conf_next;
    logic                  awaiting_reg, awaiting_next;
    logic [RST_W-1:0]      seen_rst_reg, seen_rst_next;
    logic [COUNT_BITS-1:0] base_reg, base_next;

    logic [COUNT_BITS-1:0] conf_reg, conf_next;
    logic [RST_W-1:0]      rst_cnt_reg, rst_cnt_next;
    logic [GLUE_W-1:0]     fast_reg, fast_next;
    logic [GLUE_W-1:0]     slow_reg, slow_next;
    logic [GLUE_W-1:0]     diff_reg, diff_next;
    logic [MAG_W-1:0]      mag_reg, mag_next;
    logic [SQ_W-1:0]       sq_reg, sq_next;
    logic                  sat_reg, sat_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    scale_t                scale_reg, scale_next;
    logic                  res_reg, res_next;

    logic [MUL_W-1:0]      mul_a, mul_b;
    logic [PROD_W-1:0]     prod;
    logic [ACC_W-1:0]      addend, acc_base, acc_sum;
    logic [WIN_W-1:0]      w1;
    logic [CMP_W-1:0]      var_ext, var_q4, var_400, slow_sq, slow_sq9;
    logic [FS_W-1:0]       fast_ext, slow_ext, fast20, slow23, slow17;
    logic [COUNT_BITS-1:0] since;
    logic                  pass;

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign do_restart = do_restart_reg;

    assign prod = mul_a * mul_b;
    assign w1   = (window_reg == '0) ? '0 : window_reg - WIN_W'(1);

    always_comb
    begin
        case (state_reg)
            ST_MAG:
            begin
                mul_a = diff_reg;
                mul_b = MUL_W'(w1);
            end
            ST_M0:
            begin
                mul_a = mag_reg[MUL_W-1:0];
                mul_b = mag_reg[MUL_W-1:0];
            end
            ST_M1:
            begin
                mul_a = mag_reg[MUL_W-1:0];
                mul_b = MUL_W'(mag_reg[MAG_W-1:MUL_W]);
            end
            ST_M2:
            begin
                mul_a = MUL_W'(mag_reg[MAG_W-1:MUL_W]);
                mul_b = MUL_W'(mag_reg[MAG_W-1:MUL_W]);
            end
            ST_K0:
            begin
                mul_a = var_reg[MUL_W-1:0];
                mul_b = KEEP_COEF;
            end
            ST_K1:
            begin
                mul_a = MUL_W'(var_reg[VAR_W-1:MUL_W]);
                mul_b = KEEP_COEF;
            end
            ST_N0:
            begin
                mul_a = sq_reg[MUL_W-1:0];
                mul_b = NEW_COEF;
            end
            ST_N1:
            begin
                mul_a = sq_reg[SQ_W-1:MUL_W];
                mul_b = NEW_COEF;
            end
            default:
            begin
                mul_a = slow_reg;
                mul_b = slow_reg;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_M1:          addend = ACC_W'(prod) << (MUL_W + 1);
            ST_M2:          addend = ACC_W'(prod) << (2 * MUL_W);
            ST_K1, ST_N1:   addend = ACC_W'(prod) << MUL_W;
            default:        addend = ACC_W'(prod);
        endcase
    end

    assign acc_base = (state_reg == ST_M0 || state_reg == ST_K0 || state_reg == ST_SQ)
                      ? '0 : acc_reg;
    assign acc_sum  = acc_base + addend;

    assign var_ext  = CMP_W'(var_reg);
    assign var_q4   = var_ext << (FRAC_BITS + 2);
    assign var_400  = ((var_ext << 8) + (var_ext << 7) + (var_ext << 4)) << FRAC_BITS;
    assign slow_sq  = CMP_W'(acc_reg[PROD_W-1:0]);
    assign slow_sq9 = (slow_sq << 3) + slow_sq;

    assign fast_ext = FS_W'(fast_reg);
    assign slow_ext = FS_W'(slow_reg);
    assign fast20   = (fast_ext << 4) + (fast_ext << 2);
    assign slow23   = (slow_ext << 4) + (slow_ext << 2) + (slow_ext << 1) + slow_ext;
    assign slow17   = (slow_ext << 4) + slow_ext;
    assign since    = conf_reg - base_reg;

    always_comb
    begin
        case (scale_reg)
            SCALE_UP:   pass = (fast20 > slow23);
            SCALE_DOWN: pass = (fast20 > slow17);
            default:    pass = (fast_reg > slow_reg);
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        do_restart_next = do_restart_reg;
        enable_next     = enable_reg;
        window_next     = window_reg;
        var_next        = var_reg;
        prev_fast_next  = prev_fast_reg;
        seen_conf_next  = seen_conf_reg;
        awaiting_next   = awaiting_reg;
        seen_rst_next   = seen_rst_reg;
        base_next       = base_reg;
        conf_next       = conf_reg;
        rst_cnt_next    = rst_cnt_reg;
        fast_next       = fast_reg;
        slow_next       = slow_reg;
        diff_next       = diff_reg;
        mag_next        = mag_reg;
        sq_next         = sq_reg;
        sat_next        = sat_reg;
        acc_next        = acc_reg;
        scale_next      = scale_reg;
        res_next        = res_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_write)
        begin
            case (cfg_index)
                REG_RESTART_ENABLE: enable_next = cfg_data[0];
                REG_FAST_WINDOW:    window_next = cfg_data;
                default:            ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    conf_next    = conflict_count;
                    rst_cnt_next = restart_count;
                    fast_next    = fast_avg;
                    slow_next    = slow_avg;
                    if (!enable_reg || decision_level == '0)
                    begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else if (stable_mode)
                    begin
                        res_next   = reluctant_fired;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD:
            begin
                if (rst_cnt_reg > seen_rst_reg)
                begin
                    base_next     = conf_reg;
                    seen_rst_next = rst_cnt_reg;
                end
                diff_next = (fast_reg >= prev_fast_reg) ? fast_reg - prev_fast_reg
                                                        : prev_fast_reg - fast_reg;
                state_next = ST_SQ;
                if (conf_reg > seen_conf_reg)
                begin
                    prev_fast_next = fast_reg;
                    seen_conf_next = conf_reg;
                    if (awaiting_reg)
                    begin
                        awaiting_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_MAG;
                    end
                end
            end
            ST_MAG:
            begin
                mag_next   = prod[MAG_W-1:0];
                state_next = ST_M0;
            end
            ST_M0:
            begin
                acc_next   = acc_sum;
                state_next = ST_M1;
            end
            ST_M1:
            begin
                acc_next   = acc_sum;
                state_next = ST_M2;
            end
            ST_M2:
            begin
                acc_next   = acc_sum;
                state_next = ST_K0;
            end
            ST_K0:
            begin
                sq_next    = acc_reg[FRAC_BITS +: SQ_W];
                sat_next   = |(acc_reg >> (2 * MUL_W + FRAC_BITS));
                acc_next   = acc_sum;
                state_next = ST_K1;
            end
            ST_K1:
            begin
                acc_next   = acc_sum;
                state_next = ST_N0;
            end
            ST_N0:
            begin
                acc_next   = acc_sum;
                state_next = ST_N1;
            end
            ST_N1:
            begin
                acc_next   = acc_sum;
                state_next = ST_VUPD;
            end
            ST_VUPD:
            begin
                if (sat_reg || |acc_reg[ACC_W-1:COEF_SHIFT+VAR_W])
                begin
                    var_next = VAR_MAX;
                end
                else
                begin
                    var_next = acc_reg[COEF_SHIFT +: VAR_W];
                end
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                acc_next   = acc_sum;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (var_q4 > slow_sq)
                begin
                    scale_next = SCALE_UP;
                end
                else if (var_reg == '0 || slow_sq9 > var_400)
                begin
                    scale_next = SCALE_DOWN;
                end
                else
                begin
                    scale_next = SCALE_ONE;
                end
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                res_next   = pass && (since > COUNT_BITS'(MIN_SINCE));
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    do_restart_next = res_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            do_restart_reg <= 1'b0;
            enable_reg     <= 1'b1;
            window_reg     <= FAST_WINDOW_RESET;
            var_reg        <= '0;
            prev_fast_reg  <= '0;
            seen_conf_reg  <= '0;
            awaiting_reg   <= 1'b1;
            seen_rst_reg   <= '0;
            base_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            do_restart_reg <= do_restart_next;
            enable_reg     <= enable_next;
            window_reg     <= window_next;
            var_reg        <= var_next;
            prev_fast_reg  <= prev_fast_next;
            seen_conf_reg  <= seen_conf_next;
            awaiting_reg   <= awaiting_next;
            seen_rst_reg   <= seen_rst_next;
            base_reg       <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        conf_reg    <= conf_next;
        rst_cnt_reg <= rst_cnt_next;
        fast_reg    <= fast_next;
        slow_reg    <= slow_next;
        diff_reg    <= diff_next;
        mag_reg     <= mag_next;
        sq_reg      <= sq_next;
        sat_reg     <= sat_next;
        acc_reg     <= acc_next;
        scale_reg   <= scale_next;
        res_reg     <= res_next;
    end

endmodule

// ===== design/vgrt_checker.sv =====
// Port checker for the restart trigger and the bind that attaches it.
module vgrt_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic do_restart
);
    logic       in_acc;
    logic       out_acc;
    logic [1:0] pending_reg, pending_next;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!in_acc && out_acc)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // The block works on one item at a time once it has taken it.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("in_ready high right after an item was taken");

    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result shown without an outstanding item");

    a_bounded_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> pending_reg < 2'd2)
        else $error("item taken while two items are still outstanding");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(do_restart))
        else $error("stalled result changed or dropped");

endmodule

bind variance_gated_restart_trigger vgrt_checker u_vgrt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .do_restart (do_restart)
);

// ===== sim/tb.sv =====
// Self-checking testbench for the variance gated restart trigger: random and directed checks.
`timescale 1ns / 1ps

module tb;
    import vgrt_pkg::*;

    localparam int CNT_W = 48;
    localparam int DRAIN_CYCLES = 30;
    localparam logic [47:0] VAR_SAT = '1;
    localparam logic [47:0] CNT_TOP = '1;
    localparam logic [31:0] KEEP_WT = 32'd62259;
    localparam logic [31:0] FRESH_WT = 32'd3277;
    localparam int SINCE_MIN = 50;
    localparam longint GLUE_TOP = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [CNT_W-1:0]   conflicts;
        logic [RST_W-1:0]   restarts;
        logic [GLUE_W-1:0]  fast;
        logic [GLUE_W-1:0]  slow;
        logic [LEVEL_W-1:0] level;
        logic               stable;
        logic               reluctant;
    } check_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [CNT_W-1:0]   conflict_count = '0;
    logic [RST_W-1:0]   restart_count = '0;
    logic [GLUE_W-1:0]  fast_avg = '0;
    logic [GLUE_W-1:0]  slow_avg = '0;
    logic [LEVEL_W-1:0] decision_level = '0;
    logic               stable_mode = 1'b0;
    logic               reluctant_fired = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               do_restart;
    logic               cfg_write = 1'b0;
    cfg_reg_t           cfg_index = REG_RESTART_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    check_t checks_to_send[$];
    bit     restart_answers_q[$];
    check_t on_port;
    int     send_gap = 0;
    int     stall_left = 0;
    int     failures = 0;
    bit     quiet = 1'b0;

    logic        cfg_enable = 1'b1;
    logic [15:0] cfg_window = 16'd33;

    logic [47:0] glue_var = '0;
    logic [31:0] prior_fast = '0;
    logic [47:0] newest_conflicts = '0;
    logic        no_conflict_yet = 1'b1;
    logic [31:0] newest_restarts = '0;
    logic [47:0] restart_base = '0;

    logic [47:0] gen_conflicts = 48'd200;
    logic [31:0] gen_restarts = 32'd2;

    variance_gated_restart_trigger DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .conflict_count  (conflict_count),
        .restart_count   (restart_count),
        .fast_avg        (fast_avg),
        .slow_avg        (slow_avg),
        .decision_level  (decision_level),
        .stable_mode     (stable_mode),
        .reluctant_fired (reluctant_fired),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .do_restart      (do_restart),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit predict_restart(check_t c);
        logic [15:0]  w1;
        logic [31:0]  diff;
        logic [47:0]  mag;
        logic [95:0]  mag_sq;
        logic [127:0] mix;
        logic [127:0] sq_w;
        logic [127:0] var_w;
        logic [127:0] slow_w;
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [63:0]  fast_side;
        logic [63:0]  slow_side;
        logic [63:0]  num;
        logic [63:0]  den;
        logic [47:0]  since;
        if (!cfg_enable || c.level == '0)
            return 1'b0;
        if (c.stable)
            return c.reluctant;
        if (c.restarts > newest_restarts)
        begin
            restart_base = c.conflicts;
            newest_restarts = c.restarts;
        end
        if (c.conflicts > newest_conflicts)
        begin
            if (no_conflict_yet)
                no_conflict_yet = 1'b0;
            else
            begin
                w1 = (cfg_window == 16'd0) ? 16'd0 : cfg_window - 16'd1;
                diff = (c.fast >= prior_fast) ? c.fast - prior_fast : prior_fast - c.fast;
                mag = w1 * diff;
                mag_sq = mag * mag;
                if (mag_sq[95:80] != '0)
                    glue_var = VAR_SAT;
                else
                begin
                    sq_w = {64'd0, mag_sq[79:16]};
                    var_w = {80'd0, glue_var};
                    mix = var_w * KEEP_WT + sq_w * FRESH_WT;
                    glue_var = (mix[127:64] != '0) ? VAR_SAT : mix[63:16];
                end
            end
            prior_fast = c.fast;
            newest_conflicts = c.conflicts;
        end
        num = 64'd1;
        den = 64'd1;
        var_w = {80'd0, glue_var};
        slow_w = {96'd0, c.slow};
        lhs = var_w << 18;
        rhs = slow_w * slow_w;
        if (lhs > rhs)
        begin
            num = 64'd23;
            den = 64'd20;
        end
        else
        begin
            lhs = (var_w * 128'd400) << 16;
            rhs = rhs * 128'd9;
            if (glue_var == '0 || rhs > lhs)
            begin
                num = 64'd17;
                den = 64'd20;
            end
        end
        since = c.conflicts - restart_base;
        fast_side = {32'd0, c.fast};
        slow_side = {32'd0, c.slow};
        return (fast_side * den > slow_side * num) && (since > SINCE_MIN);
    endfunction

    function automatic check_t make_check(logic [47:0] cc, logic [31:0] rc, logic [31:0] fg,
                                          logic [31:0] sg, logic [23:0] lv, logic st,
                                          logic rf);
        check_t c;
        c.conflicts = cc;
        c.restarts = rc;
        c.fast = fg;
        c.slow = sg;
        c.level = lv;
        c.stable = st;
        c.reluctant = rf;
        return c;
    endfunction

    always @(posedge clk)
    begin : feed_checks
        bit take_next;
        take_next = 1'b0;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                restart_answers_q.push_back(predict_restart(on_port));
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
                else if (checks_to_send.size() > 0)
                begin
                    if (!quiet && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(0, 17);
                    else
                        take_next = 1'b1;
                end
            end
            if (take_next)
            begin
                on_port = checks_to_send.pop_front();
                conflict_count <= on_port.conflicts;
                restart_count <= on_port.restarts;
                fast_avg <= on_port.fast;
                slow_avg <= on_port.slow;
                decision_level <= on_port.level;
                stable_mode <= on_port.stable;
                reluctant_fired <= on_port.reluctant;
                in_valid <= 1'b1;
            end
            else if (in_valid && in_ready)
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : collect_answers
        bit want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (restart_answers_q.size() == 0)
                begin
                    $error("do_restart answer with no check outstanding, actual %0b", do_restart);
                    failures++;
                end
                else
                begin
                    want = restart_answers_q.pop_front();
                    if (do_restart !== want)
                    begin
                        $error("do_restart mismatch: expected %0b, actual %0b", want, do_restart);
                        failures++;
                    end
                end
            end
            if (quiet)
                out_ready <= 1'b1;
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= (stall_left == 1);
            end
            else if ($urandom_range(0, 11) == 0)
            begin
                stall_left <= $urandom_range(1, 18);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_until_drained();
        do
            @(posedge clk);
        while (checks_to_send.size() != 0 || in_valid || restart_answers_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_solver_traffic(input int count);
        int          left;
        int          run_len;
        int          amp;
        int          skew;
        int          stable_pct;
        int          r;
        int          k;
        int          inc;
        longint      jitter;
        longint      f;
        logic [31:0] slow_base;
        logic [63:0] wide;
        check_t      c;
        left = count;
        while (left > 0)
        begin
            run_len = $urandom_range(20, 120);
            if (run_len > left)
                run_len = left;
            slow_base = $urandom_range(32'h8000, 32'h20_0000);
            case ($urandom_range(0, 3))
                0: amp = 0;
                1: amp = 32'h800;
                2: amp = 32'h4000;
                default: amp = 32'h2_0000;
            endcase
            skew = $urandom_range(0, 55);
            stable_pct = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : 0;
            for (k = 0; k < run_len; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                begin
                    wide = {$urandom, $urandom};
                    c.conflicts = wide[47:0];
                    c.restarts = $urandom;
                    c.fast = $urandom;
                    c.slow = $urandom;
                    wide = {$urandom, $urandom};
                    c.level = wide[23:0];
                    c.stable = wide[24];
                    c.reluctant = wide[25];
                    if (c.conflicts > gen_conflicts)
                        gen_conflicts = c.conflicts;
                    if (c.restarts > gen_restarts)
                        gen_restarts = c.restarts;
                end
                else
                begin
                    inc = $urandom_range(0, 99);
                    inc = (inc < 85) ? 1 : (inc < 93) ? 0 : $urandom_range(2, 40);
                    if (gen_conflicts < CNT_TOP - 48'd64)
                        gen_conflicts = gen_conflicts + 48'(inc);
                    if ($urandom_range(0, 49) == 0 && gen_restarts != '1)
                        gen_restarts = gen_restarts + 32'd1;
                    jitter = longint'($urandom_range(0, 2 * amp)) - amp;
                    f = longint'(slow_base) * (75 + skew) / 100 + jitter;
                    if (f < 0)
                        f = 0;
                    if (f > GLUE_TOP)
                        f = GLUE_TOP;
                    wide = {$urandom, $urandom};
                    c.conflicts = gen_conflicts;
                    c.restarts = gen_restarts;
                    c.fast = f[31:0];
                    c.slow = slow_base + {24'd0, wide[7:0]} - 32'd128;
                    c.level = (wide[39:32] < 8'd8) ? 24'd0 :
                              ((wide[63:40] == 24'd0) ? 24'd1 : wide[63:40]);
                    c.stable = ($urandom_range(0, 99) < stable_pct);
                    c.reluctant = wide[8];
                    if (r < 6)
                    begin
                        case ($urandom_range(0, 2))
                            0: c.conflicts = gen_conflicts - 48'($urandom_range(1, 500));
                            1: c.restarts = gen_restarts - 32'($urandom_range(1, 3));
                            default: c.level = '0;
                        endcase
                    end
                end
                checks_to_send.push_back(c);
            end
            left -= run_len;
        end
    endtask

    task automatic run_phase(input logic en, input logic [15:0] win, input int count);
        write_reg(REG_RESTART_ENABLE, {15'd0, en});
        cfg_enable = en;
        write_reg(REG_FAST_WINDOW, win);
        cfg_window = win;
        queue_solver_traffic(count);
        wait_until_drained();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        checks_to_send.push_back(make_check('0, '0, '0, '0, '0, 1'b0, 1'b0));
        checks_to_send.push_back(make_check('1, '1, '1, '0, '0, 1'b0, 1'b1));
        checks_to_send.push_back(make_check('0, '0, '1, '1, '1, 1'b1, 1'b1));
        checks_to_send.push_back(make_check('0, '0, '0, '0, 24'd1, 1'b1, 1'b0));
        checks_to_send.push_back(make_check('0, '0, 32'd1, '0, 24'd1, 1'b0, 1'b0));
        checks_to_send.push_back(make_check(48'd1, '0, 32'h3_0000, 32'h3_0000, 24'd5, 1'b0, 1'b0));
        checks_to_send.push_back(make_check(48'd60, '0, 32'h4_0000, 32'h3_0000, 24'd5, 1'b0, 1'b1));
        checks_to_send.push_back(make_check(48'd60, '0, 32'h4_0000, 32'h3_0000, 24'd7, 1'b0, 1'b0));
        checks_to_send.push_back(make_check(48'd61, 32'd1, 32'h4_0000, 32'h3_0000, 24'd7, 1'b0,
                                            1'b0));
        checks_to_send.push_back(make_check(48'd111, 32'd1, 32'h4_0000, 32'h3_0000,
                                            24'h80_0000, 1'b0, 1'b0));
        checks_to_send.push_back(make_check(48'd112, 32'd1, 32'h4_0000, 32'h3_0000,
                                            24'h7F_FFFF, 1'b0, 1'b0));
        checks_to_send.push_back(make_check(48'd113, 32'd1, '1, '1, 24'd9, 1'b0, 1'b0));
        checks_to_send.push_back(make_check(48'd114, 32'd1, '1, '0, 24'd9, 1'b0, 1'b0));
        checks_to_send.push_back(make_check(48'd115, 32'd2, 32'h3_0000, 32'h3_0000, 24'd9, 1'b0,
                                            1'b0));
        checks_to_send.push_back(make_check(48'd5, 32'd2, 32'h3_0000, 32'h3_0000, 24'd9, 1'b0,
                                            1'b0));
        checks_to_send.push_back(make_check(48'd116, '0, 32'h3_0000, 32'h3_0000, 24'd9, 1'b0,
                                            1'b0));
        checks_to_send.push_back(make_check(48'd117, 32'd2, '0, '0, 24'd9, 1'b0, 1'b1));
        checks_to_send.push_back(make_check(48'd170, 32'd2, 32'h2_8000, 32'h3_0000, 24'd9, 1'b0,
                                            1'b0));
        checks_to_send.push_back(make_check(48'd171, 32'd2, 32'h3_3000, 32'h3_0000, 24'd9, 1'b0,
                                            1'b0));
        checks_to_send.push_back(make_check(48'd172, 32'd2, 32'h3_0000, 32'h3_0000, 24'd9, 1'b0,
                                            1'b0));
        wait_until_drained();

        run_phase(1'b1, 16'd1, 200);
        run_phase(1'b0, 16'($urandom), 150);
        run_phase(1'b1, 16'd0, 150);
        run_phase(1'b1, 16'hFFFF, 200);
        run_phase(1'b1, 16'($urandom_range(2, 64)), 300);
        run_phase(1'b1, 16'd33, 300);
        quiet = 1'b1;
        run_phase(1'b1, 16'd12, 200);

        if (failures == 0)
            $display("variance_gated_restart_trigger verification clean");
        else
            $display("variance_gated_restart_trigger verification failed");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("variance_gated_restart_trigger verification failed");
        $finish;
    end

endmodule
